// ----- rtl/sed_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sed_pkg: shared types and constants for the string escape decoder
// Decode modes, result beat layout, escape characters and UTF-8 constants.
// ----------------------------------------------------------------------------
package sed_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_HEX1   = 2'd2,
        MODE_HEX2   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_end;
        logic       run_last;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    localparam logic [7:0] CODE_ASCII_MAX    = 8'h7F;
    localparam logic [7:0] UTF8_LEAD         = 8'hC0;
    localparam logic [7:0] UTF8_CONT         = 8'h80;
    localparam logic [7:0] UTF8_PAYLOAD_MASK = 8'h3F;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h41 + 8'd10);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ----- rtl/string_escape_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_escape_decoder_core: backslash escape decoder with \xHH to UTF-8
// Decodes a string literal one source byte per beat into output byte beats.
// ----------------------------------------------------------------------------
// Channel | Handshake          | Payload
// in      | in_valid/in_ready  | in_byte, final_byte
// out     | out_valid/out_ready| out_byte, byte_valid, string_end, run_last
//
// One input beat per cycle unless the result register is stalled or holds a
// UTF-8 pair; an accepted beat's decode lands in the two-slot result register.
// A two-byte UTF-8 result holds off the input until its lead byte is taken.
// Reset returns the decoder to normal text mode with an empty result register.
// in_ready follows out_ready combinationally when one result is left.
// ----------------------------------------------------------------------------
module string_escape_decoder_core
    import sed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       string_end,
    output logic       run_last
);

    mode_t      mode_reg, mode_next;
    logic [3:0] nibble_reg, nibble_next;
    logic       bad_reg, bad_next;
    logic [1:0] cnt_reg, cnt_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;

    logic       in_fire, out_fire;
    hex_t       hx;
    logic       emit_plain, emit_code;
    logic [7:0] plain_byte, code_val;
    logic [1:0] n_res;
    result_t    r0, r1;

    assign out_fire = out_valid && out_ready;
    assign in_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);
    assign in_fire  = in_valid && in_ready;
    assign hx       = hex_decode(in_byte);

    // next decode state
    always_comb
    begin
        mode_next   = mode_reg;
        nibble_next = nibble_reg;
        bad_next    = bad_reg;
        case (mode_reg)
            MODE_NORMAL:
            begin
                if (in_byte == CH_BACKSLASH) mode_next = MODE_ESC;
            end
            MODE_ESC:
            begin
                mode_next = (in_byte == CH_X) ? MODE_HEX1 : MODE_NORMAL;
            end
            MODE_HEX1:
            begin
                mode_next   = MODE_HEX2;
                bad_next    = !hx.ok;
                nibble_next = hx.ok ? hx.val : 4'd0;
            end
            MODE_HEX2:
            begin
                mode_next = MODE_NORMAL;
            end
            default:
            begin
                mode_next = MODE_NORMAL;
            end
        endcase
        // end of literal: drop all escape state
        if (final_byte) begin
            mode_next   = MODE_NORMAL;
            nibble_next = 4'd0;
            bad_next    = 1'b0;
        end
    end

    // result beats for the current input
    always_comb
    begin
        emit_plain = 1'b0;
        emit_code  = 1'b0;
        plain_byte = in_byte;
        code_val   = 8'd0;
        case (mode_reg)
            MODE_NORMAL:
            begin
                emit_plain = (in_byte != CH_BACKSLASH);
            end
            MODE_ESC:
            begin
                emit_plain = (in_byte != CH_X);
                case (in_byte)
                    CH_N:    plain_byte = CH_LF;
                    CH_T:    plain_byte = CH_TAB;
                    CH_R:    plain_byte = CH_CR;
                    default: plain_byte = in_byte;
                endcase
            end
            MODE_HEX1:
            begin
                emit_code = final_byte;
                code_val  = {4'd0, hx.ok ? hx.val : 4'd0};
            end
            MODE_HEX2:
            begin
                emit_code = 1'b1;
                if (bad_reg)     code_val = 8'd0;
                else if (!hx.ok) code_val = {4'd0, nibble_reg};
                else             code_val = {nibble_reg, hx.val};
            end
            default:
            begin
                emit_code = 1'b0;
            end
        endcase

        r0    = '0;
        r1    = '0;
        n_res = 2'd0;
        if (emit_plain) begin
            r0.out_byte   = plain_byte;
            r0.byte_valid = 1'b1;
            n_res         = 2'd1;
        end else if (emit_code) begin
            r0.byte_valid = 1'b1;
            if (code_val <= CODE_ASCII_MAX) begin
                r0.out_byte = code_val;
                n_res       = 2'd1;
            end else begin
                r0.out_byte   = UTF8_LEAD | {6'd0, code_val[7:6]};
                r1.out_byte   = UTF8_CONT | (code_val & UTF8_PAYLOAD_MASK);
                r1.byte_valid = 1'b1;
                n_res         = 2'd2;
            end
        end

        // a final beat always yields at least the end marker
        if (final_byte && n_res == 2'd0) n_res = 2'd1;

        if (n_res == 2'd2) begin
            r1.string_end = final_byte;
            r1.run_last   = 1'b1;
        end else begin
            r0.string_end = final_byte;
            r0.run_last   = 1'b1;
        end
    end

    // result register
    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (in_fire) begin
            cnt_next   = n_res;
            slot0_next = r0;
            slot1_next = r1;
        end else if (out_fire) begin
            if (cnt_reg == 2'd2) begin
                // advance the second byte of the pair
                slot0_next = slot1_reg;
                cnt_next   = 2'd1;
            end else begin
                cnt_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= MODE_NORMAL;
            nibble_reg <= 4'd0;
            bad_reg    <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (in_fire) begin
                mode_reg   <= mode_next;
                nibble_reg <= nibble_next;
                bad_reg    <= bad_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign out_valid  = (cnt_reg != 2'd0);
    assign out_byte   = slot0_reg.out_byte;
    assign byte_valid = slot0_reg.byte_valid;
    assign string_end = slot0_reg.string_end;
    assign run_last   = slot0_reg.run_last;

endmodule

// ----- rtl/sed_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sed_checker: port-level checks for the string escape decoder
// Watches the result channel for beat-sequence rules of the decoder.
// ----------------------------------------------------------------------------
module sed_checker
    import sed_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       string_end,
    input logic       run_last
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(byte_valid) && $stable(string_end) && $stable(run_last))
        else $error("stalled result beat changed");

    // an empty beat is only the end marker
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> out_byte == 8'd0 && string_end && run_last)
        else $error("bad end marker beat");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end |-> run_last)
        else $error("string end without run last");

    // first of a pair is a UTF-8 lead byte and its partner follows
    a_pair_lead: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> byte_valid && out_byte[7:6] == 2'b11)
        else $error("non-final beat is not a UTF-8 lead byte");

    a_pair_next: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last && out_ready |=> out_valid && out_byte[7:6] == 2'b10)
        else $error("UTF-8 continuation beat missing");

endmodule

bind string_escape_decoder_core sed_checker u_sed_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .string_end (string_end),
    .run_last   (run_last)
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for string_escape_decoder_core
// Drives string literal bytes through the input channel. A directed table
// covers the escapes, the hex forms and the truncated endings first. Random
// literals and noise bytes follow, under three idling mixes on both sides.
// Every beat is checked against the in-bench model or a typed row's results.
// ----------------------------------------------------------------------------
module tb;
    import sed_pkg::*;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
        logic       typed;
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } beat_t;

    localparam result_t NO_RES = '0;
    localparam int      N_DIR  = 34;

    // Rows with typed == 1 carry their own expected results; others use the model.
    localparam beat_t DIR_TBL [N_DIR] = '{
        '{8'h00,        1'b0, 1'b1, 2'd1, '{8'h00, 1'b1, 1'b0, 1'b1}, NO_RES},
        '{8'hFF,        1'b0, 1'b1, 2'd1, '{8'hFF, 1'b1, 1'b0, 1'b1}, NO_RES},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{CH_N,         1'b0, 1'b1, 2'd1, '{CH_LF, 1'b1, 1'b0, 1'b1}, NO_RES},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{CH_T,         1'b0, 1'b1, 2'd1, '{CH_TAB, 1'b1, 1'b0, 1'b1}, NO_RES},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{CH_R,         1'b0, 1'b1, 2'd1, '{CH_CR, 1'b1, 1'b0, 1'b1}, NO_RES},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{CH_DQUOTE,    1'b0, 1'b1, 2'd1, '{CH_DQUOTE, 1'b1, 1'b0, 1'b1}, NO_RES},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{CH_SQUOTE,    1'b0, 1'b1, 2'd1, '{CH_SQUOTE, 1'b1, 1'b0, 1'b1}, NO_RES},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd1, '{CH_BACKSLASH, 1'b1, 1'b0, 1'b1}, NO_RES},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{"q",          1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        // two-byte UTF-8 from \xFf
        '{CH_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_X,         1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{"F",          1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{"f",          1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        // leading space is not a digit
        '{CH_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_X,         1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{" ",          1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{"7",          1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        // second byte not a digit: first digit alone
        '{CH_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_X,         1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{"7",          1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{"z",          1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        // truncated endings
        '{CH_BACKSLASH, 1'b1, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b1, 1'b1}, NO_RES},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{CH_X,         1'b1, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b1, 1'b1}, NO_RES},
        '{CH_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_X,         1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{"a",          1'b1, 1'b0, 2'd0, NO_RES, NO_RES}
    };

    localparam string HEX_CHARS = "0123456789abcdefABCDEF";

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte    = 8'h00;
    logic       final_byte = 1'b0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic       run_last;

    int         in_idle_pct  = 0;
    int         out_idle_pct = 0;
    int         beats_sent   = 0;
    int         errors       = 0;

    beat_t      beat_q[$];
    result_t    decoded_q[$];

    mode_t      mode_q = MODE_NORMAL;
    logic [3:0] nib_q  = 4'h0;
    logic       bad_q  = 1'b0;

    string_escape_decoder_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .string_end (string_end),
        .run_last   (run_last)
    );

    always #1 clk = ~clk;

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - 48;
        if (c >= "a" && c <= "f") return int'(c) - 87;
        if (c >= "A" && c <= "F") return int'(c) - 55;
        return -1;
    endfunction

    // Advance the decoder state by one source byte and return its result beats.
    task automatic decode_beat(input logic [7:0] c, input logic fin,
                               output result_t r0, output result_t r1, output int n);
        int         d;
        logic       has_lit;
        logic       has_code;
        logic [7:0] lit;
        logic [7:0] code;
        d        = hex_digit(c);
        has_lit  = 1'b0;
        has_code = 1'b0;
        lit      = 8'h00;
        code     = 8'h00;
        r0       = '0;
        r1       = '0;
        n        = 0;
        case (mode_q)
            MODE_NORMAL:
            begin
                if (c == CH_BACKSLASH) mode_q = MODE_ESC;
                else
                begin
                    has_lit = 1'b1;
                    lit     = c;
                end
            end
            MODE_ESC:
            begin
                mode_q  = MODE_NORMAL;
                has_lit = 1'b1;
                case (c)
                    CH_N:      lit = CH_LF;
                    CH_T:      lit = CH_TAB;
                    CH_R:      lit = CH_CR;
                    CH_X:
                    begin
                        has_lit = 1'b0;
                        mode_q  = MODE_HEX1;
                    end
                    default:   lit = c;
                endcase
            end
            MODE_HEX1:
            begin
                bad_q  = (d < 0);
                nib_q  = (d < 0) ? 4'h0 : 4'(d);
                mode_q = MODE_HEX2;
                if (fin)
                begin
                    has_code = 1'b1;
                    code     = bad_q ? 8'h00 : {4'h0, nib_q};
                end
            end
            default:
            begin
                has_code = 1'b1;
                if (bad_q) code = 8'h00;
                else if (d < 0) code = {4'h0, nib_q};
                else code = {nib_q, 4'(d)};
                mode_q = MODE_NORMAL;
            end
        endcase
        if (has_lit)
        begin
            r0 = '{lit, 1'b1, 1'b0, 1'b0};
            n  = 1;
        end
        if (has_code)
        begin
            if (code <= CODE_ASCII_MAX)
            begin
                r0 = '{code, 1'b1, 1'b0, 1'b0};
                n  = 1;
            end
            else
            begin
                r0 = '{UTF8_LEAD | (code >> 6), 1'b1, 1'b0, 1'b0};
                r1 = '{UTF8_CONT | (code & UTF8_PAYLOAD_MASK), 1'b1, 1'b0, 1'b0};
                n  = 2;
            end
        end
        if (fin)
        begin
            if (n == 0) n = 1;
            if (n == 2) r1.string_end = 1'b1;
            else r0.string_end = 1'b1;
            mode_q = MODE_NORMAL;
            nib_q  = 4'h0;
            bad_q  = 1'b0;
        end
        if (n == 2) r1.run_last = 1'b1;
        else if (n == 1) r0.run_last = 1'b1;
    endtask

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    // Check result beats first, then queue the results of the accepted input beat.
    always @(posedge clk)
    begin : monitor
        beat_t   bt;
        result_t want;
        result_t p0;
        result_t p1;
        int      pn;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected result beat: out_byte %02h", out_byte);
                    errors++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.out_byte, out_byte);
                        errors++;
                    end
                    if (byte_valid !== want.byte_valid)
                    begin
                        $error("byte_valid: expected %b, got %b", want.byte_valid, byte_valid);
                        errors++;
                    end
                    if (string_end !== want.string_end)
                    begin
                        $error("string_end: expected %b, got %b", want.string_end, string_end);
                        errors++;
                    end
                    if (run_last !== want.run_last)
                    begin
                        $error("run_last: expected %b, got %b", want.run_last, run_last);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                bt = beat_q.pop_front();
                decode_beat(bt.b, bt.fin, p0, p1, pn);
                if (bt.typed)
                begin
                    pn = bt.n;
                    p0 = bt.r0;
                    p1 = bt.r1;
                end
                if (pn > 0) decoded_q.push_back(p0);
                if (pn > 1) decoded_q.push_back(p1);
            end
        end
    end

    task automatic send_beat(input beat_t bt);
        beat_q.push_back(bt);
        beats_sent++;
        @(negedge clk);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        in_byte    <= bt.b;
        final_byte <= bt.fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        beat_t bt;
        bt     = '0;
        bt.b   = b;
        bt.fin = fin;
        send_beat(bt);
    endtask

    function automatic logic [7:0] hex_or_noise();
        if ($urandom_range(0, 99) < 85)
            return HEX_CHARS[$urandom_range(0, HEX_CHARS.len() - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Build a mostly well-formed literal, sometimes cut off inside an escape.
    task automatic send_literal();
        logic [7:0] lit_q[$];
        logic [7:0] b;
        int         kind;
        repeat ($urandom_range(1, 10))
        begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3:
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CH_BACKSLASH) b = "A";
                    lit_q.push_back(b);
                end
                4, 5:
                begin
                    lit_q.push_back(CH_BACKSLASH);
                    case ($urandom_range(0, 5))
                        0:       lit_q.push_back(CH_N);
                        1:       lit_q.push_back(CH_T);
                        2:       lit_q.push_back(CH_R);
                        3:       lit_q.push_back(CH_DQUOTE);
                        4:       lit_q.push_back(CH_SQUOTE);
                        default: lit_q.push_back(CH_BACKSLASH);
                    endcase
                end
                6:
                begin
                    lit_q.push_back(CH_BACKSLASH);
                    lit_q.push_back(8'($urandom_range(0, 255)));
                end
                7, 8:
                begin
                    lit_q.push_back(CH_BACKSLASH);
                    lit_q.push_back(CH_X);
                    lit_q.push_back(hex_or_noise());
                    lit_q.push_back(hex_or_noise());
                end
                default: lit_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        case ($urandom_range(0, 9))
            0: lit_q.push_back(CH_BACKSLASH);
            1:
            begin
                lit_q.push_back(CH_BACKSLASH);
                lit_q.push_back(CH_X);
            end
            2:
            begin
                lit_q.push_back(CH_BACKSLASH);
                lit_q.push_back(CH_X);
                lit_q.push_back(hex_or_noise());
            end
            default: ;
        endcase
        foreach (lit_q[i]) send_byte(lit_q[i], i == lit_q.size() - 1);
    endtask

    task automatic run_random(input int target);
        while (beats_sent < target)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                repeat ($urandom_range(1, 8))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end
            else send_literal();
        end
    endtask

    // Drop valid and hold off until every expected result has drained.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        in_idle_pct  = 18;
        out_idle_pct = 75;
        for (int i = 0; i < N_DIR; i++) send_beat(DIR_TBL[i]);
        run_random(540);
        drain();

        in_idle_pct  = 75;
        out_idle_pct = 18;
        run_random(1045);
        drain();

        in_idle_pct  = 0;
        out_idle_pct = 0;
        run_random(1550);
        drain();
        repeat (20) @(posedge clk);

        if (errors == 0 && decoded_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
